[sv/esd_pkg.sv]
// esd_pkg: shared types and codes for the event subscriber dispatcher
// transaction structs, action and status codes, sequencer states, queue types
// no dependencies
`timescale 1ns / 1ps

package esd_pkg;

   // request action codes
   typedef enum logic [2:0] {
      ACT_SUBSCRIBE   = 3'd0,
      ACT_UNSUBSCRIBE = 3'd1,
      ACT_PUBLISH     = 3'd2,
      ACT_POST        = 3'd3,
      ACT_PROCESS     = 3'd4
   } action_type;

   // response status codes
   typedef enum logic [3:0] {
      ST_OK        = 4'd0,
      ST_BAD       = 4'd1,
      ST_FULL      = 4'd2,
      ST_DUP       = 4'd3,
      ST_NOT_FOUND = 4'd4,
      ST_Q_FULL    = 4'd5,
      ST_Q_EMPTY   = 4'd6,
      ST_NO_SUBS   = 4'd7,
      ST_DELIVERY  = 4'd8
   } status_type;

   // sequencer states
   typedef enum logic [2:0] {
      S_IDLE,
      S_LOOKUP,
      S_CHECK,
      S_SCAN,
      S_MOVE_WR,
      S_DELIV
   } state_type;

   // request transaction
   typedef struct packed {
      logic [2:0]  action;
      logic [7:0]  event_type;
      logic [7:0]  handler_id;
      logic [31:0] argument;
   } req_type;

   // response transaction
   typedef struct packed {
      logic [3:0]  status;
      logic [7:0]  target_handler;
      logic [7:0]  delivered_type;
      logic [31:0] delivered_argument;
      logic        last;
   } rsp_type;

   // one pending event in the ring queue
   typedef struct packed {
      logic [7:0]  event_type;
      logic [31:0] argument;
   } qent_type;

   // ring queue status towards the sequencer
   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

[sv/esd_queue.sv]
// esd_queue: pending-event ring queue with registered head read
// depends on esd_pkg for the entry and status structs
`timescale 1ns / 1ps

module esd_queue #(
   parameter int DEPTH = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic              pop,
   input  esd_pkg::qent_type wr_entry,
   output esd_pkg::qent_type rd_entry,
   output esd_pkg::qstat_type status
);
   import esd_pkg::*;

   localparam int QW = $clog2(DEPTH);
   localparam int FW = $clog2(DEPTH + 1);

   qent_type        mem [DEPTH];
   logic [QW-1:0]   head_ff, head_in;
   logic [QW-1:0]   tail_ff, tail_in;
   logic [FW-1:0]   fill_ff, fill_in;
   qent_type        rd_ff;

   // pointer and fill update, wrap at any depth
   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      fill_in = fill_ff;
      if (push) begin
         tail_in = (tail_ff == QW'(DEPTH - 1)) ? '0 : tail_ff + QW'(1);
      end
      if (pop) begin
         head_in = (head_ff == QW'(DEPTH - 1)) ? '0 : head_ff + QW'(1);
      end
      if (push && !pop) begin
         fill_in = fill_ff + FW'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - FW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         fill_ff <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         fill_ff <= fill_in;
      end
   end

   // storage: write at tail, registered read at head
   always_ff @(posedge clock) begin
      if (push) begin
         mem[tail_ff] <= wr_entry;
      end
      rd_ff <= mem[head_ff];
   end

   assign rd_entry     = rd_ff;
   assign status.full  = (fill_ff == FW'(DEPTH));
   assign status.empty = (fill_ff == '0);

   // checks
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      !(push && status.full)) else $error("push into full queue");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      !(pop && status.empty)) else $error("pop from empty queue");
   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FW'(DEPTH)) else $error("queue fill out of range");

endmodule

[sv/event_subscriber_dispatcher_unit.sv]
// event_subscriber_dispatcher_unit: publish/subscribe dispatcher top level
// depends on esd_pkg and esd_queue
//
//  channel | ports                    | handshake
//  --------+--------------------------+-------------------------------------
//  request | start, busy, req_data    | taken on start high with busy low
//  result  | rsp_strobe, rsp_data     | one cycle per result, cannot stall
//
// each transaction passes lookup and check states, then may walk the list,
// scanning or delivering; an unsubscribe hit adds the move state. post,
// bad requests, empty lists and a full subscribe list end in check, and
// process pops the queue there and publishes the event. the single table
// read port and the one compare unit walk the list one entry per cycle.
// reset clears counts and queue pointers at once, no clearing pass. busy
// is high while a transaction is in flight; results are registered.
`timescale 1ns / 1ps

module event_subscriber_dispatcher_unit #(
   parameter int EVENT_TYPES          = 16,
   parameter int SUBSCRIBERS_PER_TYPE = 5,
   parameter int QUEUE_DEPTH          = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  esd_pkg::req_type req_data,
   output logic             rsp_strobe,
   output esd_pkg::rsp_type rsp_data
);
   import esd_pkg::*;

   localparam int HW = EVENT_TYPES * SUBSCRIBERS_PER_TYPE;
   localparam int AW = (HW > 1) ? $clog2(HW) : 1;
   localparam int TW = (EVENT_TYPES > 1) ? $clog2(EVENT_TYPES) : 1;
   localparam int PW = (SUBSCRIBERS_PER_TYPE > 1) ? $clog2(SUBSCRIBERS_PER_TYPE) : 1;
   localparam int CW = $clog2(SUBSCRIBERS_PER_TYPE + 1);

   state_type       state_ff, state_in;
   logic [2:0]      act_ff, act_in;
   logic [7:0]      typ_ff, typ_in;
   logic [7:0]      id_ff, id_in;
   logic [31:0]     arg_ff, arg_in;
   logic [CW-1:0]   n_ff, n_in;
   logic [PW-1:0]   pos_ff, pos_in;
   logic [AW-1:0]   base_ff, base_in;

   logic            rsp_strobe_ff, rsp_strobe_in;
   rsp_type         rsp_data_ff, rsp_data_in;

   // subscriber table and per-type counts
   logic [7:0]      tbl_mem [HW];
   logic [7:0]      tbl_q_ff;
   logic [CW-1:0]   cnt_mem [EVENT_TYPES];
   logic [EVENT_TYPES-1:0] cnt_vld_ff;
   logic [CW-1:0]   cnt_q_ff;
   logic            cnt_v_q_ff;

   logic            tbl_we;
   logic [PW-1:0]   tbl_rd_pos;
   logic [PW-1:0]   tbl_wr_pos;
   logic [7:0]      tbl_wdata;
   logic [AW-1:0]   tbl_raddr;
   logic [AW-1:0]   tbl_waddr;
   logic            cnt_we;
   logic [CW-1:0]   cnt_wdata;

   logic [TW-1:0]   tidx;
   logic            typ_ok;
   logic [CW-1:0]   n_now;
   logic            pos_end;
   logic            hit;

   logic            q_push;
   logic            q_pop;
   qent_type        q_wr;
   qent_type        q_rd;
   qstat_type       q_st;

   // ring queue of posted events
   esd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .pop      (q_pop),
      .wr_entry (q_wr),
      .rd_entry (q_rd),
      .status   (q_st)
   );

   assign q_wr.event_type = typ_ff;
   assign q_wr.argument   = arg_ff;

   // shared decode of the held transaction
   assign tidx    = typ_ff[TW-1:0];
   assign typ_ok  = ({1'b0, typ_ff} < 9'(EVENT_TYPES));
   assign n_now   = cnt_v_q_ff ? cnt_q_ff : '0;
   assign pos_end = ((CW'(pos_ff) + CW'(1)) == n_ff);
   assign hit     = (tbl_q_ff == id_ff);

   assign tbl_raddr = base_ff + AW'(tbl_rd_pos);
   assign tbl_waddr = base_ff + AW'(tbl_wr_pos);

   // sequencer: next state, memory controls and result issue
   always_comb begin
      state_in      = state_ff;
      act_in        = act_ff;
      typ_in        = typ_ff;
      id_in         = id_ff;
      arg_in        = arg_ff;
      n_in          = n_ff;
      pos_in        = pos_ff;
      base_in       = base_ff;
      tbl_we        = 1'b0;
      tbl_rd_pos    = '0;
      tbl_wr_pos    = pos_ff;
      tbl_wdata     = id_ff;
      cnt_we        = 1'b0;
      cnt_wdata     = n_ff;
      q_push        = 1'b0;
      q_pop         = 1'b0;
      rsp_strobe_in = 1'b0;
      rsp_data_in.status             = ST_OK;
      rsp_data_in.target_handler     = '0;
      rsp_data_in.delivered_type     = typ_ff;
      rsp_data_in.delivered_argument = '0;
      rsp_data_in.last               = 1'b1;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               act_in   = req_data.action;
               typ_in   = req_data.event_type;
               id_in    = req_data.handler_id;
               arg_in   = req_data.argument;
               state_in = S_LOOKUP;
            end
         end

         // count read in flight, list base computed
         S_LOOKUP: begin
            base_in  = AW'(tidx) * AW'(SUBSCRIBERS_PER_TYPE);
            state_in = S_CHECK;
         end

         // count available, first list entry read issued
         S_CHECK: begin
            n_in       = n_now;
            pos_in     = '0;
            tbl_rd_pos = '0;
            state_in   = S_IDLE;
            case (act_ff)
               ACT_SUBSCRIBE: begin
                  if (!typ_ok || id_ff == '0) begin
                     rsp_strobe_in      = 1'b1;
                     rsp_data_in.status = ST_BAD;
                  end else if (n_now >= CW'(SUBSCRIBERS_PER_TYPE)) begin
                     rsp_strobe_in      = 1'b1;
                     rsp_data_in.status = ST_FULL;
                  end else if (n_now == '0) begin
                     tbl_we             = 1'b1;
                     tbl_wr_pos         = '0;
                     tbl_wdata          = id_ff;
                     cnt_we             = 1'b1;
                     cnt_wdata          = CW'(1);
                     rsp_strobe_in      = 1'b1;
                     rsp_data_in.status = ST_OK;
                  end else begin
                     state_in = S_SCAN;
                  end
               end
               ACT_UNSUBSCRIBE: begin
                  if (!typ_ok || id_ff == '0) begin
                     rsp_strobe_in      = 1'b1;
                     rsp_data_in.status = ST_BAD;
                  end else if (n_now == '0) begin
                     rsp_strobe_in      = 1'b1;
                     rsp_data_in.status = ST_NOT_FOUND;
                  end else begin
                     state_in = S_SCAN;
                  end
               end
               ACT_PUBLISH: begin
                  if (!typ_ok) begin
                     rsp_strobe_in                  = 1'b1;
                     rsp_data_in.status             = ST_BAD;
                     rsp_data_in.delivered_argument = arg_ff;
                  end else if (n_now == '0) begin
                     rsp_strobe_in                  = 1'b1;
                     rsp_data_in.status             = ST_NO_SUBS;
                     rsp_data_in.delivered_argument = arg_ff;
                  end else begin
                     state_in = S_DELIV;
                  end
               end
               ACT_POST: begin
                  rsp_strobe_in = 1'b1;
                  if (q_st.full) begin
                     rsp_data_in.status = ST_Q_FULL;
                  end else begin
                     q_push             = 1'b1;
                     rsp_data_in.status = ST_OK;
                  end
               end
               ACT_PROCESS: begin
                  if (q_st.empty) begin
                     rsp_strobe_in              = 1'b1;
                     rsp_data_in.status         = ST_Q_EMPTY;
                     rsp_data_in.delivered_type = '0;
                  end else begin
                     // popped item goes round again as a publish
                     q_pop    = 1'b1;
                     typ_in   = q_rd.event_type;
                     arg_in   = q_rd.argument;
                     act_in   = ACT_PUBLISH;
                     state_in = S_LOOKUP;
                  end
               end
               default: begin
                  rsp_strobe_in      = 1'b1;
                  rsp_data_in.status = ST_BAD;
               end
            endcase
         end

         // one list entry compared per cycle, next read issued alongside
         S_SCAN: begin
            if (act_ff == ACT_SUBSCRIBE) begin
               if (hit) begin
                  rsp_strobe_in      = 1'b1;
                  rsp_data_in.status = ST_DUP;
                  state_in           = S_IDLE;
               end else if (pos_end) begin
                  tbl_we             = 1'b1;
                  tbl_wr_pos         = PW'(n_ff);
                  tbl_wdata          = id_ff;
                  cnt_we             = 1'b1;
                  cnt_wdata          = n_ff + CW'(1);
                  rsp_strobe_in      = 1'b1;
                  rsp_data_in.status = ST_OK;
                  state_in           = S_IDLE;
               end else begin
                  pos_in     = pos_ff + PW'(1);
                  tbl_rd_pos = pos_ff + PW'(1);
               end
            end else begin
               if (hit) begin
                  // fetch the last entry to fill the hole
                  tbl_rd_pos = PW'(n_ff - CW'(1));
                  state_in   = S_MOVE_WR;
               end else if (pos_end) begin
                  rsp_strobe_in      = 1'b1;
                  rsp_data_in.status = ST_NOT_FOUND;
                  state_in           = S_IDLE;
               end else begin
                  pos_in     = pos_ff + PW'(1);
                  tbl_rd_pos = pos_ff + PW'(1);
               end
            end
         end

         // last entry moved into the removed slot
         S_MOVE_WR: begin
            tbl_we             = 1'b1;
            tbl_wr_pos         = pos_ff;
            tbl_wdata          = tbl_q_ff;
            cnt_we             = 1'b1;
            cnt_wdata          = n_ff - CW'(1);
            rsp_strobe_in      = 1'b1;
            rsp_data_in.status = ST_OK;
            state_in           = S_IDLE;
         end

         // one delivery per cycle in list order
         S_DELIV: begin
            rsp_strobe_in                  = 1'b1;
            rsp_data_in.status             = ST_DELIVERY;
            rsp_data_in.target_handler     = tbl_q_ff;
            rsp_data_in.delivered_argument = arg_ff;
            rsp_data_in.last               = pos_end;
            if (pos_end) begin
               state_in = S_IDLE;
            end else begin
               pos_in     = pos_ff + PW'(1);
               tbl_rd_pos = pos_ff + PW'(1);
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // transaction and result payload registers
   always_ff @(posedge clock) begin
      act_ff      <= act_in;
      typ_ff      <= typ_in;
      id_ff       <= id_in;
      arg_ff      <= arg_in;
      n_ff        <= n_in;
      pos_ff      <= pos_in;
      base_ff     <= base_in;
      rsp_data_ff <= rsp_data_in;
   end

   // subscriber table: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (tbl_we) begin
         tbl_mem[tbl_waddr] <= tbl_wdata;
      end
      tbl_q_ff <= tbl_mem[tbl_raddr];
   end

   // per-type counts, registered read
   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[tidx] <= cnt_wdata;
      end
      if (typ_ok) begin
         cnt_q_ff   <= cnt_mem[tidx];
         cnt_v_q_ff <= cnt_vld_ff[tidx];
      end
   end

   // count valid bits, an unwritten count reads as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_vld_ff <= '0;
      end else if (cnt_we) begin
         cnt_vld_ff[tidx] <= 1'b1;
      end
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   // checks
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.last |-> !busy)
      else $error("final result while sequencer still busy");
   a_non_last_delivery: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.last |-> rsp_data.status == ST_DELIVERY)
      else $error("non-final result is not a delivery");
   a_target_only_delivery: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.status != ST_DELIVERY |-> rsp_data.target_handler == '0)
      else $error("target set on a non-delivery result");
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted transaction did not raise busy");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      cnt_we |-> cnt_wdata <= CW'(SUBSCRIBERS_PER_TYPE))
      else $error("subscriber count beyond list size");

endmodule

[dv/event_subscriber_dispatcher_unit_tb.sv]
// event_subscriber_dispatcher_unit_tb: self-checking bench for the event dispatcher
// directed table then weighted random commands, checked against an in-bench predictor
// depends on esd_pkg and event_subscriber_dispatcher_unit
`timescale 1ns / 1ps

module event_subscriber_dispatcher_unit_tb;
   import esd_pkg::*;

   localparam int CLOCK_PERIOD  = 8;
   localparam int RESET_CYCLES  = 12;
   localparam int N_TYPES       = 16;
   localparam int LIST_DEPTH    = 5;
   localparam int QUEUE_SLOTS   = 8;
   localparam int DIRECTED_ROWS = 25;
   localparam int RANDOM_ITEMS  = 245;
   localparam int CALM_TAIL     = 40;
   localparam int TAIL_CYCLES   = 16;
   localparam int QUIET_LIMIT   = 500;

   // action codes the block does not define
   localparam logic [2:0] ACT_RESERVED_LO = 3'd5;
   localparam logic [2:0] ACT_RESERVED_HI = 3'd7;

   typedef struct {
      req_type item;
      bit      fixed;
      rsp_type rsp;
   } stim_row_type;

   logic    clock = 1'b0;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_strobe;
   rsp_type rsp_data;

   // expectation typed into the table, travels with the request
   bit      fixed_valid;
   rsp_type fixed_rsp;

   int items_taken = 0;
   int error_count = 0;
   int quiet_cycles = 0;

   // predictor state: subscriber lists and the pending event ring
   logic [7:0]  sub_list [N_TYPES][LIST_DEPTH];
   int          sub_count [N_TYPES];
   logic [7:0]  evq_type [QUEUE_SLOTS];
   logic [31:0] evq_arg [QUEUE_SLOTS];
   int          evq_head = 0;
   int          evq_tail = 0;
   int          evq_fill = 0;

   rsp_type fresh_results [$];
   rsp_type due_results [$];

   stim_row_type directed_rows [DIRECTED_ROWS];

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   event_subscriber_dispatcher_unit dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   initial begin
      foreach (sub_count[t]) sub_count[t] = 0;
   end

   task automatic emit(input logic [3:0] st, input logic [7:0] tgt, input logic [7:0] et,
                       input logic [31:0] arg, input bit fin);
      rsp_type r;
      r.status             = st;
      r.target_handler     = tgt;
      r.delivered_type     = et;
      r.delivered_argument = arg;
      r.last               = fin;
      fresh_results.push_back(r);
   endtask

   // one delivery per subscriber in list order, or a single status result
   task automatic fan_out(input logic [7:0] et, input logic [31:0] arg);
      if (et >= N_TYPES) begin
         emit(ST_BAD, 8'd0, et, arg, 1'b1);
      end else if (sub_count[et] == 0) begin
         emit(ST_NO_SUBS, 8'd0, et, arg, 1'b1);
      end else begin
         for (int i = 0; i < sub_count[et]; i++)
            emit(ST_DELIVERY, sub_list[et][i], et, arg, i + 1 == sub_count[et]);
      end
   endtask

   // work out the results of one transaction and advance the predictor state
   task automatic forecast(input req_type r);
      int n;
      int hit;
      fresh_results.delete();
      case (r.action)
         ACT_SUBSCRIBE, ACT_UNSUBSCRIBE: begin
            if (r.event_type >= N_TYPES || r.handler_id == 8'd0) begin
               emit(ST_BAD, 8'd0, r.event_type, 32'd0, 1'b1);
            end else begin
               n = sub_count[r.event_type];
               hit = -1;
               for (int i = n - 1; i >= 0; i--)
                  if (sub_list[r.event_type][i] == r.handler_id) hit = i;
               if (r.action == ACT_SUBSCRIBE) begin
                  if (n >= LIST_DEPTH) begin
                     emit(ST_FULL, 8'd0, r.event_type, 32'd0, 1'b1);
                  end else if (hit >= 0) begin
                     emit(ST_DUP, 8'd0, r.event_type, 32'd0, 1'b1);
                  end else begin
                     sub_list[r.event_type][n] = r.handler_id;
                     sub_count[r.event_type] = n + 1;
                     emit(ST_OK, 8'd0, r.event_type, 32'd0, 1'b1);
                  end
               end else if (hit >= 0) begin
                  // last entry fills the hole
                  sub_list[r.event_type][hit] = sub_list[r.event_type][n - 1];
                  sub_count[r.event_type] = n - 1;
                  emit(ST_OK, 8'd0, r.event_type, 32'd0, 1'b1);
               end else begin
                  emit(ST_NOT_FOUND, 8'd0, r.event_type, 32'd0, 1'b1);
               end
            end
         end
         ACT_PUBLISH: fan_out(r.event_type, r.argument);
         ACT_POST: begin
            if (evq_fill >= QUEUE_SLOTS) begin
               emit(ST_Q_FULL, 8'd0, r.event_type, 32'd0, 1'b1);
            end else begin
               evq_type[evq_tail] = r.event_type;
               evq_arg[evq_tail]  = r.argument;
               evq_tail = (evq_tail + 1) % QUEUE_SLOTS;
               evq_fill++;
               emit(ST_OK, 8'd0, r.event_type, 32'd0, 1'b1);
            end
         end
         ACT_PROCESS: begin
            if (evq_fill == 0) begin
               emit(ST_Q_EMPTY, 8'd0, 8'd0, 32'd0, 1'b1);
            end else begin
               n = evq_head;
               evq_head = (evq_head + 1) % QUEUE_SLOTS;
               evq_fill--;
               fan_out(evq_type[n], evq_arg[n]);
            end
         end
         default: emit(ST_BAD, 8'd0, r.event_type, 32'd0, 1'b1);
      endcase
   endtask

   task automatic compare_field(input string field, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
         error_count++;
      end
   endtask

   // result check first, then expectations of a transaction taken at this edge
   always @(posedge clock) begin : monitor_proc
      rsp_type want;
      if (!reset) begin
         if (rsp_strobe) begin
            if (due_results.size() == 0) begin
               $display({"%0t ns: unexpected result, expected none, ",
                         "actual status %0h tgt %0h type %0h arg %0h last %0b"},
                        $time, rsp_data.status, rsp_data.target_handler,
                        rsp_data.delivered_type, rsp_data.delivered_argument, rsp_data.last);
               error_count++;
            end else begin
               want = due_results.pop_front();
               compare_field("status", 32'(want.status), 32'(rsp_data.status));
               compare_field("target_handler", 32'(want.target_handler),
                             32'(rsp_data.target_handler));
               compare_field("delivered_type", 32'(want.delivered_type),
                             32'(rsp_data.delivered_type));
               compare_field("delivered_argument", want.delivered_argument,
                             rsp_data.delivered_argument);
               compare_field("last", 32'(want.last), 32'(rsp_data.last));
            end
         end
         if (start && !busy) begin
            forecast(req_data);
            if (fixed_valid) due_results.push_back(fixed_rsp);
            else foreach (fresh_results[i]) due_results.push_back(fresh_results[i]);
            items_taken++;
         end
      end
   end

   // watchdog on cycles with no transaction in either direction
   always @(posedge clock) begin
      if (!reset) begin
         if ((start && !busy) || rsp_strobe) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t ns: no progress for %0d cycles", $time, QUIET_LIMIT);
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   function automatic stim_row_type row(input logic [2:0] act, input logic [7:0] et,
                                        input logic [7:0] hid, input logic [31:0] arg,
                                        input bit fixed, input logic [3:0] st,
                                        input logic [7:0] rtype, input logic [31:0] rarg);
      stim_row_type s;
      s.item.action                = act;
      s.item.event_type            = et;
      s.item.handler_id            = hid;
      s.item.argument              = arg;
      s.fixed                      = fixed;
      s.rsp.status                 = st;
      s.rsp.target_handler         = 8'd0;
      s.rsp.delivered_type         = rtype;
      s.rsp.delivered_argument     = rarg;
      s.rsp.last                   = 1'b1;
      return s;
   endfunction

   // present one transaction at the falling edge and hold it until taken
   task automatic send_item(input req_type item, input bit fixed, input rsp_type rsp);
      int taken;
      taken       = items_taken;
      start       = 1'b1;
      req_data    = item;
      fixed_valid = fixed;
      fixed_rsp   = rsp;
      do @(negedge clock); while (items_taken == taken);
   endtask

   task automatic drain_results();
      start = 1'b0;
      while (due_results.size() != 0) @(negedge clock);
   endtask

   initial begin
      req_type item;
      rsp_type no_rsp;
      int      pick;
      int      post_w;
      int      proc_w;
      int      phase;

      reset       = 1'b1;
      start       = 1'b0;
      req_data    = '0;
      fixed_valid = 1'b0;
      fixed_rsp   = '0;
      no_rsp      = '0;

      directed_rows = '{
         row(ACT_PROCESS,     8'h5c, 8'h00, 32'h0,        1'b1, ST_Q_EMPTY,   8'h00, 32'h0),
         row(ACT_PUBLISH,     8'h03, 8'h00, 32'ha5a55a5a, 1'b1, ST_NO_SUBS,   8'h03, 32'ha5a55a5a),
         row(ACT_SUBSCRIBE,   8'h10, 8'h01, 32'h0,        1'b1, ST_BAD,       8'h10, 32'h0),
         row(ACT_SUBSCRIBE,   8'hff, 8'hff, 32'hffffffff, 1'b1, ST_BAD,       8'hff, 32'h0),
         row(ACT_SUBSCRIBE,   8'h00, 8'h00, 32'h0,        1'b1, ST_BAD,       8'h00, 32'h0),
         row(ACT_UNSUBSCRIBE, 8'h00, 8'h00, 32'h0,        1'b1, ST_BAD,       8'h00, 32'h0),
         row(ACT_PUBLISH,     8'hff, 8'h00, 32'hffffffff, 1'b1, ST_BAD,       8'hff, 32'hffffffff),
         row(ACT_RESERVED_LO, 8'h2a, 8'h11, 32'h5555aaaa, 1'b1, ST_BAD,       8'h2a, 32'h0),
         row(ACT_RESERVED_HI, 8'hff, 8'hff, 32'hffffffff, 1'b1, ST_BAD,       8'hff, 32'h0),
         row(ACT_SUBSCRIBE,   8'h0f, 8'hff, 32'h0,        1'b0, ST_OK,        8'h00, 32'h0),
         row(ACT_SUBSCRIBE,   8'h0f, 8'h01, 32'h0,        1'b0, ST_OK,        8'h00, 32'h0),
         row(ACT_SUBSCRIBE,   8'h0f, 8'h80, 32'h0,        1'b0, ST_OK,        8'h00, 32'h0),
         row(ACT_SUBSCRIBE,   8'h0f, 8'h55, 32'h0,        1'b0, ST_OK,        8'h00, 32'h0),
         row(ACT_SUBSCRIBE,   8'h0f, 8'haa, 32'h0,        1'b0, ST_OK,        8'h00, 32'h0),
         row(ACT_SUBSCRIBE,   8'h0f, 8'h02, 32'h0,        1'b1, ST_FULL,      8'h0f, 32'h0),
         row(ACT_PUBLISH,     8'h0f, 8'h00, 32'hdeadbeef, 1'b0, ST_OK,        8'h00, 32'h0),
         row(ACT_UNSUBSCRIBE, 8'h0f, 8'h01, 32'h0,        1'b0, ST_OK,        8'h00, 32'h0),
         row(ACT_PUBLISH,     8'h0f, 8'h00, 32'h0,        1'b0, ST_OK,        8'h00, 32'h0),
         row(ACT_SUBSCRIBE,   8'h00, 8'h07, 32'h0,        1'b0, ST_OK,        8'h00, 32'h0),
         row(ACT_SUBSCRIBE,   8'h00, 8'h07, 32'h0,        1'b1, ST_DUP,       8'h00, 32'h0),
         row(ACT_UNSUBSCRIBE, 8'h00, 8'h09, 32'h0,        1'b1, ST_NOT_FOUND, 8'h00, 32'h0),
         row(ACT_POST,        8'hc8, 8'h00, 32'h12345678, 1'b1, ST_OK,        8'hc8, 32'h0),
         row(ACT_PROCESS,     8'h00, 8'h00, 32'h0,        1'b1, ST_BAD,       8'hc8, 32'h12345678),
         row(ACT_POST,        8'h0f, 8'h00, 32'hffffffff, 1'b0, ST_OK,        8'h00, 32'h0),
         row(ACT_PROCESS,     8'h00, 8'h00, 32'h0,        1'b0, ST_OK,        8'h00, 32'h0)
      };

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed table
      foreach (directed_rows[i])
         send_item(directed_rows[i].item, directed_rows[i].fixed, directed_rows[i].rsp);
      drain_results();

      // random commands, bias on the ring queue shifts between phases
      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         phase = (k / 60) % 3;
         post_w = (phase == 1) ? 30 : (phase == 2) ? 5 : 15;
         proc_w = (phase == 2) ? 30 : (phase == 1) ? 5 : 15;

         pick = $urandom_range(0, 99);
         if (pick < 22) item.action = ACT_SUBSCRIBE;
         else if (pick < 34) item.action = ACT_UNSUBSCRIBE;
         else if (pick < 48) item.action = ACT_PUBLISH;
         else if (pick < 48 + post_w) item.action = ACT_POST;
         else if (pick < 48 + post_w + proc_w) item.action = ACT_PROCESS;
         else if (pick >= 96) item.action = 3'($urandom_range(ACT_RESERVED_LO, ACT_RESERVED_HI));
         else item.action = ACT_PUBLISH;

         // few types and ids so lists fill, repeat and empty again
         pick = $urandom_range(0, 9);
         if (pick < 6) item.event_type = 8'($urandom_range(0, 3));
         else if (pick < 9) item.event_type = 8'($urandom_range(0, N_TYPES - 1));
         else item.event_type = 8'($urandom_range(0, 255));

         if ($urandom_range(0, 19) == 0) item.handler_id = 8'd0;
         else if ($urandom_range(0, 4) == 0) item.handler_id = 8'($urandom_range(1, 255));
         else item.handler_id = 8'($urandom_range(1, 6));

         item.argument = $urandom;

         // sender gaps in bursts, with idle-free stretches and a calm tail
         if (k < RANDOM_ITEMS - CALM_TAIL && (k / 25) % 3 != 2 &&
             $urandom_range(0, 3) == 0) begin
            start = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clock);
         end

         // hold off once mid-run until everything outstanding is back
         if (k == RANDOM_ITEMS / 2) drain_results();

         send_item(item, 1'b0, no_rsp);
      end

      drain_results();
      repeat (TAIL_CYCLES) @(negedge clock);

      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
